@@ src/fbc_pkg.sv @@
package fbc_pkg;

	localparam int ELEM_WIDTH      = 16;
	localparam int PLANE_WIDTH     = ELEM_WIDTH + 1;
	localparam int ROW_WIDTH       = 64;
	localparam int NUM_ROWS        = 4;
	localparam int NUM_COLS        = 4;
	localparam int NUM_AXES        = 3;
	localparam int NUM_PLANES      = 6;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam int PL_LEFT   = 0;
	localparam int PL_RIGHT  = 1;
	localparam int PL_BOTTOM = 2;
	localparam int PL_TOP    = 3;
	localparam int PL_NEAR   = 4;
	localparam int PL_FAR    = 5;

	localparam int COL_D = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ROW_ONE   = 3'd0,
		REG_ROW_TWO   = 3'd1,
		REG_ROW_THREE = 3'd2,
		REG_ROW_FOUR  = 3'd3
	} reg_index_t;

	typedef logic [ROW_WIDTH-1:0] row_t;
	typedef logic signed [PLANE_WIDTH-1:0] plane_comp_t;

	localparam row_t ROW_ONE_RESET   = 64'h0000_0000_0000_0100;
	localparam row_t ROW_TWO_RESET   = 64'h0000_0000_0100_0000;
	localparam row_t ROW_THREE_RESET = 64'h0000_0100_0000_0000;
	localparam row_t ROW_FOUR_RESET  = 64'h0100_0000_0000_0000;

	function automatic plane_comp_t row_elem(row_t row, int col);
		logic signed [ELEM_WIDTH-1:0] e;
		e = signed'(row[col*ELEM_WIDTH +: ELEM_WIDTH]);
		return PLANE_WIDTH'(e);
	endfunction

endpackage

@@ src/frustum_box_cull_top.sv @@
// Frustum culling of axis-aligned boxes against the six clip planes of a
// view-projection matrix written through the configuration port (rows one to
// four, indices 0 to 3, identity after reset; other indices are ignored).
// One box is taken per cycle while the output is not stalled; its visible
// flag passes through an input register, a register of the eighteen
// plane-by-corner products (one 17 x COORD_WIDTH multiplier each), and the
// result register after the per-plane sums and sign tests. The plane set is
// registered from the matrix row registers, which take a write directly.
module frustum_box_cull_top #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [fbc_pkg::ROW_WIDTH-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       min_x,
	input  logic signed [COORD_WIDTH-1:0]       min_y,
	input  logic signed [COORD_WIDTH-1:0]       min_z,
	input  logic signed [COORD_WIDTH-1:0]       max_x,
	input  logic signed [COORD_WIDTH-1:0]       max_y,
	input  logic signed [COORD_WIDTH-1:0]       max_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                visible
);
	import fbc_pkg::*;

	localparam int PROD_WIDTH = PLANE_WIDTH + COORD_WIDTH;
	localparam int D_WIDTH    = PLANE_WIDTH + FRAC_BITS;
	localparam int TERM_WIDTH = (PROD_WIDTH > D_WIDTH) ? PROD_WIDTH : D_WIDTH;
	localparam int ACC_WIDTH  = TERM_WIDTH + 2;

	row_t        row_q   [NUM_ROWS];
	plane_comp_t plane_q [NUM_PLANES][NUM_COLS];
	plane_comp_t plane_d [NUM_PLANES][NUM_COLS];

	logic                          adv;
	logic                          valid_s1, valid_s2, valid_s3;
	logic signed [COORD_WIDTH-1:0] lo_s1 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi_s1 [NUM_AXES];
	logic signed [PROD_WIDTH-1:0]  prod_s2 [NUM_PLANES][NUM_AXES];
	logic signed [ACC_WIDTH-1:0]   d_s2 [NUM_PLANES];
	logic                          visible_s3;
	logic                          vis_d;

	assign adv       = !valid_s3 || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s3;
	assign visible   = visible_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_ONE_RESET;
			row_q[1] <= ROW_TWO_RESET;
			row_q[2] <= ROW_THREE_RESET;
			row_q[3] <= ROW_FOUR_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ROW_ONE:   row_q[0] <= cfg_data;
				REG_ROW_TWO:   row_q[1] <= cfg_data;
				REG_ROW_THREE: row_q[2] <= cfg_data;
				REG_ROW_FOUR:  row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_COLS; c++) begin
			plane_d[PL_LEFT][c]   = row_elem(row_q[3], c) + row_elem(row_q[0], c);
			plane_d[PL_RIGHT][c]  = row_elem(row_q[3], c) - row_elem(row_q[0], c);
			plane_d[PL_BOTTOM][c] = row_elem(row_q[3], c) + row_elem(row_q[1], c);
			plane_d[PL_TOP][c]    = row_elem(row_q[3], c) - row_elem(row_q[1], c);
			plane_d[PL_NEAR][c]   = row_elem(row_q[2], c);
			plane_d[PL_FAR][c]    = row_elem(row_q[3], c) - row_elem(row_q[2], c);
		end
	end

	always_ff @(posedge clk) begin
		plane_q <= plane_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s1[0] <= min_x;
			lo_s1[1] <= min_y;
			lo_s1[2] <= min_z;
			hi_s1[0] <= max_x;
			hi_s1[1] <= max_y;
			hi_s1[2] <= max_z;
		end
	end

	// pick the far corner per axis and multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_s2[p][a] <= PROD_WIDTH'(plane_q[p][a]) *
						PROD_WIDTH'(plane_q[p][a][PLANE_WIDTH-1] ? lo_s1[a] : hi_s1[a]);
				end
				d_s2[p] <= ACC_WIDTH'(plane_q[p][COL_D]) <<< FRAC_BITS;
			end
		end
	end

	always_comb begin
		logic signed [ACC_WIDTH-1:0] acc;
		vis_d = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			acc = d_s2[p] + ACC_WIDTH'(prod_s2[p][0]) + ACC_WIDTH'(prod_s2[p][1])
				+ ACC_WIDTH'(prod_s2[p][2]);
			if (acc[ACC_WIDTH-1]) begin
				vis_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			visible_s3 <= vis_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transfer did not reach the input register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s1) && $stable(valid_s2) && $stable(valid_s3))
		else $error("pipeline moved during an output stall");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && adv |=> out_valid)
		else $error("product stage item lost before the output");
`endif

endmodule
